// ===== hdl/tmd_pkg.sv =====
// Shared types and constants of the TLV message deframer.
package tmd_pkg;

  localparam int unsigned CountW     = 17;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [7:0] VersionVal       = 8'd1;
  localparam logic [CountW-1:0] MagicLen  = 17'd5;
  localparam logic [CountW-1:0] VersionOfs = 17'd5;
  localparam logic [CountW-1:0] HdrSizeOfs = 17'd6;
  localparam logic [CountW-1:0] TypeOfs    = 17'd7;
  localparam logic [CountW-1:0] SeqOfs     = 17'd10;
  localparam logic [CountW-1:0] SeqEnd     = 17'd18;
  localparam logic [CountW-1:0] PlenOfs    = 17'd18;
  localparam logic [CountW-1:0] PlenLowOfs = 17'd19;
  localparam logic [CountW-1:0] FixedHdr   = 17'd20;
  localparam logic [7:0] FixedHdrByte      = 8'd20;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_FIELD    = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_END_OK   = 3'd3,
    KIND_END_ERR  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SHORT     = 3'd1,
    ERR_MAGIC     = 3'd2,
    ERR_VERSION   = 3'd3,
    ERR_HDR_SIZE  = 3'd4,
    ERR_LENGTH    = 3'd5,
    ERR_TRUNCATED = 3'd6
  } err_e;

  typedef enum logic [3:0] {
    PH_TYPE   = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_VALUE  = 4'b1000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  message_kind;
    logic [63:0] sequence_number;
    logic [7:0]  field_tag;
    logic [15:0] field_size;
    logic [7:0]  value_byte;
    err_e        error_code;
    logic        run_last;
  } result_t;

  // Up to two results produced by one accepted byte, packed from slot one.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } emit_t;

  function automatic logic [7:0] magic_byte(logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h54; // T
      3'd1:    b = 8'h47; // G
      3'd2:    b = 8'h41; // A
      3'd3:    b = 8'h50; // P
      3'd4:    b = 8'h50; // P
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/tmd_parser.sv =====
// Header capture, field walk and verdict logic of the TLV message deframer.
module tmd_parser
  import tmd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output emit_t      emit_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        hdr_len_q, hdr_len_d;
  logic [15:0]       pay_len_q, pay_len_d;
  logic [7:0]        msg_type_q, msg_type_d;
  logic [63:0]       seq_q, seq_d;
  logic              magic_bad_q, magic_bad_d;
  logic              version_bad_q, version_bad_d;
  phase_e            phase_q, phase_d;
  logic [7:0]        ftype_q, ftype_d;
  logic [15:0]       left_q, left_d;
  logic [15:0]       declared_q, declared_d;

  logic              main_v;
  result_t           main_r, end_r;
  logic              walk;
  logic [CountW-1:0] span_cur, span_next;
  logic [15:0]       left_dec;
  err_e              err;

  assign span_cur  = {9'd0, hdr_len_q} + {1'b0, pay_len_q};
  assign span_next = {9'd0, hdr_len_d} + {1'b0, pay_len_d};
  assign left_dec  = left_q - 16'd1;

  assign walk = (count_q >= FixedHdr) && !magic_bad_q && !version_bad_q &&
                (hdr_len_q >= FixedHdrByte) && (count_q >= {9'd0, hdr_len_q}) &&
                (count_q < span_cur);

  always_comb begin
    count_d       = count_q;
    ovf_d         = ovf_q;
    hdr_len_d     = hdr_len_q;
    pay_len_d     = pay_len_q;
    msg_type_d    = msg_type_q;
    seq_d         = seq_q;
    magic_bad_d   = magic_bad_q;
    version_bad_d = version_bad_q;
    phase_d       = phase_q;
    ftype_d       = ftype_q;
    left_d        = left_q;
    declared_d    = declared_q;
    main_v        = 1'b0;
    main_r        = '0;

    // Header capture by byte offset.
    if (count_q < MagicLen) begin
      if (data_i != magic_byte(count_q[2:0])) magic_bad_d = 1'b1;
    end else if (count_q == VersionOfs) begin
      if (data_i != VersionVal) version_bad_d = 1'b1;
    end else if (count_q == HdrSizeOfs) begin
      hdr_len_d = data_i;
    end else if (count_q == TypeOfs) begin
      msg_type_d = data_i;
    end else if (count_q >= SeqOfs && count_q < SeqEnd) begin
      seq_d = {seq_q[55:0], data_i};
    end else if (count_q == PlenOfs) begin
      pay_len_d = {data_i, 8'h00};
    end else if (count_q == PlenLowOfs) begin
      pay_len_d = {pay_len_q[15:8], data_i};
      if (!magic_bad_q && !version_bad_q && hdr_len_q >= FixedHdrByte) begin
        main_v      = 1'b1;
        main_r.kind = KIND_HEADER;
      end
    end

    // Field walk inside the declared payload.
    if (walk) begin
      unique case (phase_q)
        PH_TYPE: begin
          ftype_d = data_i;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          left_d  = {data_i, 8'h00};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          left_d            = {left_q[15:8], data_i};
          declared_d        = {left_q[15:8], data_i};
          main_v            = 1'b1;
          main_r.kind       = KIND_FIELD;
          main_r.field_tag  = ftype_q;
          main_r.field_size = {left_q[15:8], data_i};
          phase_d = ({left_q[15:8], data_i} == 16'd0) ? PH_TYPE : PH_VALUE;
        end
        PH_VALUE: begin
          main_v            = 1'b1;
          main_r.kind       = KIND_VALUE;
          main_r.field_tag  = ftype_q;
          main_r.field_size = declared_q;
          main_r.value_byte = data_i;
          left_d            = left_dec;
          if (left_dec == 16'd0) phase_d = PH_TYPE;
        end
        default: phase_d = PH_TYPE;
      endcase
    end

    // Saturate the byte counter.
    if (count_q != CountMax) count_d = count_q + 17'd1;
    else ovf_d = 1'b1;

    main_r.message_kind    = msg_type_d;
    main_r.sequence_number = seq_d;
    main_r.run_last        = !last_i;
  end

  // Verdict in check order on the final byte.
  always_comb begin
    priority if (count_d < FixedHdr)           err = ERR_SHORT;
    else if (magic_bad_d)                      err = ERR_MAGIC;
    else if (version_bad_d)                    err = ERR_VERSION;
    else if (hdr_len_d < FixedHdrByte)         err = ERR_HDR_SIZE;
    else if (ovf_d || count_d != span_next)    err = ERR_LENGTH;
    else if (phase_d != PH_TYPE)               err = ERR_TRUNCATED;
    else                                       err = ERR_NONE;

    end_r                 = '0;
    end_r.kind            = (err == ERR_NONE) ? KIND_END_OK : KIND_END_ERR;
    end_r.message_kind    = msg_type_d;
    end_r.sequence_number = seq_d;
    end_r.error_code      = err;
    end_r.run_last        = 1'b1;
  end

  always_comb begin
    emit_o.count  = accept_i ? ({1'b0, main_v} + {1'b0, last_i}) : 2'd0;
    emit_o.first  = main_v ? main_r : end_r;
    emit_o.second = end_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      ovf_q         <= 1'b0;
      hdr_len_q     <= '0;
      pay_len_q     <= '0;
      msg_type_q    <= '0;
      seq_q         <= '0;
      magic_bad_q   <= 1'b0;
      version_bad_q <= 1'b0;
      phase_q       <= PH_TYPE;
      ftype_q       <= '0;
      left_q        <= '0;
      declared_q    <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        count_q       <= '0;
        ovf_q         <= 1'b0;
        hdr_len_q     <= '0;
        pay_len_q     <= '0;
        msg_type_q    <= '0;
        seq_q         <= '0;
        magic_bad_q   <= 1'b0;
        version_bad_q <= 1'b0;
        phase_q       <= PH_TYPE;
        ftype_q       <= '0;
        left_q        <= '0;
        declared_q    <= '0;
      end else begin
        count_q       <= count_d;
        ovf_q         <= ovf_d;
        hdr_len_q     <= hdr_len_d;
        pay_len_q     <= pay_len_d;
        msg_type_q    <= msg_type_d;
        seq_q         <= seq_d;
        magic_bad_q   <= magic_bad_d;
        version_bad_q <= version_bad_d;
        phase_q       <= phase_d;
        ftype_q       <= ftype_d;
        left_q        <= left_d;
        declared_q    <= declared_d;
      end
    end
  end

endmodule

// ===== hdl/tmd_result_fifo.sv =====
// Result queue of the TLV message deframer: two pushes, one pop per cycle.
module tmd_result_fifo
  import tmd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  emit_t   emit_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    valid_o,
  output logic    room_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  function automatic logic [PtrW-1:0] advance(logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_next = advance(wr_q);
  assign pop     = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign room_o  = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    unique case (emit_i.count)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = wr_next;
      default: wr_d = advance(wr_next);
    endcase
    rd_d  = pop ? advance(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(emit_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.count != 2'd0) mem_q[wr_q] <= emit_i.first;
    if (emit_i.count == 2'd2) mem_q[wr_next] <= emit_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/tlv_message_deframer_core.sv =====
// Top level of the TLV message deframer: byte stream in, result stream out.
//
// The deframer takes one message byte per cycle and reports what it finds: a
// header result once the fixed 20-byte header has checked out (magic "TGAPP",
// version 1, header size of at least 20), a field start for each type/length
// pair of the payload, one result per value byte, and a verdict (ok or the
// first failing check) on the byte flagged by s_axis_tlast. Header bytes past
// offset 19 up to the declared header size are skipped, as are bytes beyond
// the declared payload; the latter end in a length-mismatch verdict. Rate: one
// byte per cycle while s_axis_tready is high, the byte handled by the parser's
// state registers and a short compare path; its results are written into the
// result queue registers as the byte is taken. Results leave through a queue
// of ResultDepth entries at one per cycle while m_axis_tready is high; a final
// byte that also carries a header, field start or value result yields two
// results. The result kind travels on m_axis_tuser. s_axis_tready is high
// while the queue has room for two results, so with the output side taking
// every cycle the input never stalls inside a message.
module tlv_message_deframer_core
  import tmd_pkg::*;
#(
  parameter int unsigned ResultDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tlast,  // last_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] message_kind, [71:8] sequence_number, [79:72] field_tag,
  // [95:80] field_size, [103:96] value_byte, [106:104] error_code, [111:107] zero
  output logic [111:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // [2:0] kind
  output logic         m_axis_tlast   // run_last
);

  logic    accept;
  logic    room;
  emit_t   emit;
  result_t head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  // Parse the byte and update header and field state.
  tmd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .emit_o   (emit)
  );

  // Hold results until the output side takes them.
  tmd_result_fifo #(
    .Depth (ResultDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (emit),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room_o  (room)
  );

  assign m_axis_tdata = {5'b00000, head.error_code, head.value_byte, head.field_size,
                         head.field_tag, head.sequence_number, head.message_kind};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.run_last;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the TLV message deframer core.
module tb_top;
  import tmd_pkg::*;

  localparam logic [39:0] MagicWord  = 40'h54_47_41_50_50; // "TGAPP", first byte on top
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned RandomBytes = 880;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } stream_item_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;

  tlv_message_deframer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Byte stream still to be offered, and results the parser model expects.
  stream_item_t byte_stream [$];
  result_t      predicted_results [$];
  logic [7:0]   body [$];

  int unsigned send_gap_pct = 14;
  int unsigned take_gap_pct = 58;
  logic        hold_go = 1'b0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_fail = 0;
  int unsigned verdict_tally [7];

  // Parser model state.
  logic [CountW-1:0] byte_cnt = '0;
  logic              cnt_ovf = 1'b0;
  logic [7:0]        hdr_len = 8'h00;
  logic [15:0]       pay_len = 16'h0000;
  logic [7:0]        msg_type = 8'h00;
  logic [63:0]       seq_val = 64'h0;
  logic              magic_bad = 1'b0;
  logic              ver_bad = 1'b0;
  phase_e            field_ph = PH_TYPE;
  logic [7:0]        cur_tag = 8'h00;
  logic [15:0]       left_cnt = 16'h0000;
  logic [15:0]       decl_size = 16'h0000;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic result_t make_result(kind_e k, logic [7:0] tag, logic [15:0] size,
                                          logic [7:0] val, err_e code);
    result_t r;
    r.kind            = k;
    r.message_kind    = msg_type;
    r.sequence_number = seq_val;
    r.field_tag       = tag;
    r.field_size      = size;
    r.value_byte      = val;
    r.error_code      = code;
    r.run_last        = 1'b0;
    return r;
  endfunction

  function automatic string show(result_t r);
    return $sformatf("kind=%0d type=%h seq=%h tag=%h size=%h val=%h err=%0d last=%b",
                     r.kind, r.message_kind, r.sequence_number, r.field_tag,
                     r.field_size, r.value_byte, r.error_code, r.run_last);
  endfunction

  // Append one item to the stream still to be offered.
  task automatic queue_byte(input logic [7:0] d, input logic l);
    stream_item_t it;
    it.data    = d;
    it.is_last = l;
    byte_stream.insert(byte_stream.size(), it);
  endtask

  // Advance the parser model by one accepted byte and queue what it yields.
  task automatic parse_byte(input logic [7:0] b, input logic is_last);
    result_t           outs [2];
    int                n;
    int                k;
    logic [CountW-1:0] pos;
    logic [CountW-1:0] frame_len;
    logic              hdr_good;
    err_e              verdict;
    n = 0;
    pos = byte_cnt;
    if (pos < MagicLen) begin
      if (b != MagicWord[8 * (4 - int'(pos)) +: 8]) begin
        magic_bad = 1'b1;
      end
    end else if (pos == VersionOfs) begin
      if (b != VersionVal) begin
        ver_bad = 1'b1;
      end
    end else if (pos == HdrSizeOfs) begin
      hdr_len = b;
    end else if (pos == TypeOfs) begin
      msg_type = b;
    end else if (pos >= SeqOfs && pos < SeqEnd) begin
      seq_val = {seq_val[55:0], b};
    end else if (pos == PlenOfs) begin
      pay_len = {b, 8'h00};
    end else if (pos == PlenLowOfs) begin
      pay_len[7:0] = b;
      if (!magic_bad && !ver_bad && hdr_len >= FixedHdrByte) begin
        outs[n] = make_result(KIND_HEADER, 8'h00, 16'h0000, 8'h00, ERR_NONE);
        n++;
      end
    end

    // Walk fields only inside the declared payload of a sound header.
    hdr_good  = !magic_bad && !ver_bad && hdr_len >= FixedHdrByte;
    frame_len = {9'b0, hdr_len} + {1'b0, pay_len};
    if (pos >= FixedHdr && hdr_good && pos >= {9'b0, hdr_len} && pos < frame_len) begin
      case (field_ph)
        PH_TYPE: begin
          cur_tag  = b;
          field_ph = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          left_cnt = {b, 8'h00};
          field_ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          left_cnt[7:0] = b;
          decl_size = left_cnt;
          outs[n] = make_result(KIND_FIELD, cur_tag, decl_size, 8'h00, ERR_NONE);
          n++;
          field_ph = (left_cnt == 16'h0000) ? PH_TYPE : PH_VALUE;
        end
        default: begin
          outs[n] = make_result(KIND_VALUE, cur_tag, decl_size, b, ERR_NONE);
          n++;
          left_cnt = left_cnt - 16'd1;
          if (left_cnt == 16'h0000) begin
            field_ph = PH_TYPE;
          end
        end
      endcase
    end

    if (byte_cnt < CountMax) begin
      byte_cnt = byte_cnt + 1'b1;
    end else begin
      cnt_ovf = 1'b1;
    end

    if (is_last) begin
      if (byte_cnt < FixedHdr) begin
        verdict = ERR_SHORT;
      end else if (magic_bad) begin
        verdict = ERR_MAGIC;
      end else if (ver_bad) begin
        verdict = ERR_VERSION;
      end else if (hdr_len < FixedHdrByte) begin
        verdict = ERR_HDR_SIZE;
      end else if (cnt_ovf || byte_cnt != frame_len) begin
        verdict = ERR_LENGTH;
      end else if (field_ph != PH_TYPE) begin
        verdict = ERR_TRUNCATED;
      end else begin
        verdict = ERR_NONE;
      end
      outs[n] = make_result((verdict == ERR_NONE) ? KIND_END_OK : KIND_END_ERR,
                            8'h00, 16'h0000, 8'h00, verdict);
      n++;
      verdict_tally[int'(verdict)]++;
      // Clear everything for the next message.
      byte_cnt  = '0;
      cnt_ovf   = 1'b0;
      hdr_len   = 8'h00;
      pay_len   = 16'h0000;
      msg_type  = 8'h00;
      seq_val   = 64'h0;
      magic_bad = 1'b0;
      ver_bad   = 1'b0;
      field_ph  = PH_TYPE;
      cur_tag   = 8'h00;
      left_cnt  = 16'h0000;
      decl_size = 16'h0000;
    end

    if (n > 0) begin
      outs[n-1].run_last = 1'b1;
    end
    for (k = 0; k < n; k++) begin
      predicted_results.insert(predicted_results.size(), outs[k]);
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    logic    same;
    got.kind            = kind_e'(m_axis_tuser);
    got.message_kind    = m_axis_tdata[7:0];
    got.sequence_number = m_axis_tdata[71:8];
    got.field_tag       = m_axis_tdata[79:72];
    got.field_size      = m_axis_tdata[95:80];
    got.value_byte      = m_axis_tdata[103:96];
    got.error_code      = err_e'(m_axis_tdata[106:104]);
    got.run_last        = m_axis_tlast;
    n_out++;
    if (predicted_results.size() == 0) begin
      if (n_fail < 10) begin
        $display("unexpected result %0d: %s", n_out, show(got));
      end
      n_fail++;
    end else begin
      want = predicted_results.pop_front();
      same = (got.kind === want.kind) && (got.message_kind === want.message_kind) &&
             (got.sequence_number === want.sequence_number) &&
             (got.field_tag === want.field_tag) && (got.field_size === want.field_size) &&
             (got.value_byte === want.value_byte) &&
             (got.error_code === want.error_code) && (got.run_last === want.run_last);
      if (!same) begin
        if (n_fail < 10) begin
          $display("mismatch at result %0d", n_out);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        n_fail++;
      end
    end
  endtask

  task automatic add_field(input logic [7:0] tag, input logic [15:0] size);
    int k;
    body.insert(body.size(), tag);
    body.insert(body.size(), size[15:8]);
    body.insert(body.size(), size[7:0]);
    for (k = 0; k < int'(size); k++) begin
      body.insert(body.size(), 8'($urandom));
    end
  endtask

  task automatic new_body(input int n_fields, input int max_size);
    int f;
    body = {};
    for (f = 0; f < n_fields; f++) begin
      add_field(8'($urandom), 16'($urandom_range(max_size)));
    end
  endtask

  // Queue one message: header, then body; optionally corrupt one byte, cut the
  // stream after cut bytes, or append extra junk bytes past the frame.
  task automatic emit_frame(input logic [7:0] hlen, input logic [7:0] mtype,
                            input logic [63:0] seq, input logic [15:0] plen,
                            input int bad_at, input int cut, input int extra);
    logic [7:0] frame [$];
    int         i;
    int         n_send;
    frame = {};
    for (i = 0; i < 5; i++) begin
      frame.insert(frame.size(), MagicWord[8 * (4 - i) +: 8]);
    end
    frame.insert(frame.size(), VersionVal);
    frame.insert(frame.size(), hlen);
    frame.insert(frame.size(), mtype);
    frame.insert(frame.size(), 8'($urandom));
    frame.insert(frame.size(), 8'($urandom));
    for (i = 0; i < 8; i++) begin
      frame.insert(frame.size(), seq[8 * (7 - i) +: 8]);
    end
    frame.insert(frame.size(), plen[15:8]);
    frame.insert(frame.size(), plen[7:0]);
    for (i = 20; i < int'(hlen); i++) begin
      frame.insert(frame.size(), 8'($urandom));
    end
    for (i = 0; i < body.size(); i++) begin
      frame.insert(frame.size(), body[i]);
    end
    if (bad_at >= 0) begin
      frame[bad_at] = frame[bad_at] ^ 8'($urandom_range(1, 255));
    end
    n_send = (cut >= 0 && cut < frame.size()) ? cut : frame.size();
    for (i = 0; i < n_send; i++) begin
      queue_byte(frame[i], (i == n_send - 1) && (extra == 0));
    end
    for (i = 0; i < extra; i++) begin
      queue_byte(8'($urandom), i == extra - 1);
    end
  endtask

  // Driver: hold the offered item until taken, then advance or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_stream.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_stream[0].data;
        s_axis_tlast  <= byte_stream[0].is_last;
        void'(byte_stream.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  int unsigned hold_left = 0;
  logic        hold_taken = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken    <= 1'b1;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // Monitor: predict from accepted input first, then check accepted output.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        n_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
      end
    end
  end

  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("no progress for %0d cycles", quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_stop;
    int unsigned short_total;
    int unsigned pick;
    int          n_noise;
    int          i;
    logic [7:0]  hlen;
    logic [15:0] plen;

    // Directed: lone bytes, minimal and extreme headers, each header fault,
    // fault priority, truncation, overrun and early end.
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);
    body = {};
    emit_frame(FixedHdrByte, 8'h00, 64'h0, 16'h0000, -1, -1, 0);
    add_field(8'h00, 16'h0000);
    add_field(8'hFF, 16'd3);
    emit_frame(FixedHdrByte, 8'hFF, {64{1'b1}}, 16'(body.size()), -1, -1, 0);
    new_body(1, 4);
    add_field(8'h7E, 16'h0000);
    emit_frame(8'hFF, 8'h81, {$urandom, $urandom}, 16'(body.size()), -1, -1, 0);
    emit_frame(8'd19, 8'h12, {$urandom, $urandom}, 16'(body.size()), -1, -1, 0);
    emit_frame(8'h00, 8'h13, {$urandom, $urandom}, 16'(body.size()), -1, -1, 0);
    for (i = 0; i < 6; i++) begin
      emit_frame(FixedHdrByte, 8'h20, {$urandom, $urandom}, 16'(body.size()), i, -1, 0);
    end
    emit_frame(8'd5, 8'h21, 64'h1, 16'(body.size()), 2, -1, 0);
    emit_frame(8'd10, 8'h22, 64'h2, 16'(body.size()), 5, -1, 0);
    body = {};
    body.insert(body.size(), 8'hFF);
    body.insert(body.size(), 8'hFF);
    body.insert(body.size(), 8'hFF);
    for (i = 0; i < 4; i++) begin
      body.insert(body.size(), 8'($urandom));
    end
    emit_frame(FixedHdrByte, 8'h30, {$urandom, $urandom}, 16'd7, -1, -1, 0);
    new_body(2, 3);
    emit_frame(FixedHdrByte, 8'h31, {$urandom, $urandom}, 16'(body.size()), -1, -1, 3);
    emit_frame(FixedHdrByte, 8'h32, {$urandom, $urandom}, 16'(body.size()), -1, 19, 0);
    emit_frame(FixedHdrByte, 8'h33, {$urandom, $urandom}, 16'(body.size()), -1, 24, 0);

    // Random: mostly sound messages with random content, the rest broken.
    rand_stop = byte_stream.size() + RandomBytes;
    while (byte_stream.size() < rand_stop) begin
      pick = $urandom_range(99);
      hlen = ($urandom_range(3) == 0) ? 8'($urandom_range(21, 40)) : FixedHdrByte;
      new_body($urandom_range(4), ($urandom_range(7) == 0) ? 40 : 6);
      plen = 16'(body.size());
      if (pick < 70 || (pick < 76 && body.size() == 0)) begin
        emit_frame(hlen, 8'($urandom), {$urandom, $urandom}, plen, -1, -1, 0);
      end else if (pick < 76) begin
        plen = 16'($urandom_range(body.size() - 1));
        emit_frame(hlen, 8'($urandom), {$urandom, $urandom}, plen, -1,
                   int'(hlen) + int'(plen), 0);
      end else if (pick < 81) begin
        emit_frame(hlen, 8'($urandom), {$urandom, $urandom}, plen, -1, -1,
                   $urandom_range(1, 5));
      end else if (pick < 86) begin
        emit_frame(hlen, 8'($urandom), {$urandom, $urandom}, plen, -1,
                   $urandom_range(1, int'(hlen) + body.size() - 1), 0);
      end else if (pick < 91) begin
        emit_frame(hlen, 8'($urandom), {$urandom, $urandom}, plen,
                   $urandom_range(5), -1, 0);
      end else if (pick < 95) begin
        emit_frame(8'($urandom_range(19)), 8'($urandom), {$urandom, $urandom}, plen,
                   -1, -1, 0);
      end else begin
        n_noise = $urandom_range(1, 30);
        for (i = 0; i < n_noise; i++) begin
          queue_byte(8'($urandom), i == n_noise - 1);
        end
      end
    end
    short_total = byte_stream.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (n_in < short_total / 3);
    send_gap_pct = 58;
    take_gap_pct = 14;
    do @(negedge clk_i); while (n_in < 2 * short_total / 3);
    send_gap_pct = 0;
    take_gap_pct = 0;
    do @(negedge clk_i); while (n_in < 5 * short_total / 6);
    hold_go = 1'b1;

    do @(negedge clk_i); while (n_in < short_total);
    do @(negedge clk_i); while (predicted_results.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d input bytes and %0d results over %0d messages",
             n_in, n_out, verdict_tally.sum());
    $display("verdicts: ok %0d short %0d magic %0d version %0d hdr %0d length %0d trunc %0d",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4], verdict_tally[5], verdict_tally[6]);
    if (n_fail == 0 && predicted_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", n_fail);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/tmd_pkg.sv
hdl/tmd_parser.sv
hdl/tmd_result_fifo.sv
hdl/tlv_message_deframer_core.sv
sim/tb_top.sv
